/* rtl/itda_pkg.sv */
// Package for the integer-to-decimal-ASCII converter.
// Holds shared constants and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package itda_pkg;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned MAX_DIGITS  = 10;
   localparam int unsigned DIG_IDX_W   = 4;
   localparam int unsigned PROD_W      = 64;
   localparam int unsigned RECIP_SHIFT = 35;
   localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [VALUE_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;

   typedef struct packed {
      logic load;
      logic mul;
      logic dig;
      logic step;
      logic sel_sign;
   } ctl_cmd_type;

   typedef struct packed {
      logic negative;
      logic quot_zero;
      logic ptr_zero;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/int_to_decimal_ascii.sv */
// Top level of the integer-to-decimal-ASCII converter.
// Joins itda_ctrl and itda_datapath; uses itda_pkg.
//
//   Channel | Ports                                   | Direction
//   req     | req_valid, req_stall, req_value[31:0]   | in (one signed integer)
//   rsp     | rsp_valid, rsp_stall, rsp_ascii_char,   | out (one character)
//           | rsp_last_char                           |
//
// One number at a time: load, then per decimal digit a multiply by the reciprocal
// of ten (ST_MUL) and a subtract for the remainder (ST_DIG), then one character per
// cycle while rsp_stall is low, with the minus sign first if negative.
// Reset is synchronous and returns the controller to idle.
// rsp_stall holds the current character; req_stall is high until the last one is done.
`default_nettype none

module int_to_decimal_ascii
   import itda_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_ascii_char,
   output logic                    rsp_last_char
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   itda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itda_datapath u_datapath (
      .clock      (clock),
      .value      (req_value),
      .cmd        (cmd),
      .status     (status),
      .ascii_char (rsp_ascii_char),
      .last_char  (rsp_last_char)
   );

endmodule

`default_nettype wire

/* rtl/itda_datapath.sv */
// Datapath for the integer-to-decimal-ASCII converter: magnitude register,
// reciprocal multiply by ten, digit store and character select. Uses itda_pkg.
`default_nettype none

module itda_datapath
   import itda_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [VALUE_W-1:0]   value,
   input  wire ctl_cmd_type          cmd,
   output dp_status_type             status,
   output logic [CHAR_W-1:0]         ascii_char,
   output logic                      last_char
);

   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic                 neg_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [DIGIT_W-1:0]   digits_ff [MAX_DIGITS];
   logic [DIG_IDX_W-1:0] cnt_ff;
   logic [DIG_IDX_W-1:0] ptr_ff;
   logic [VALUE_W-1:0]   quot;
   logic [VALUE_W-1:0]   rem_full;

   assign quot     = {{(VALUE_W-QUOT_W){1'b0}}, prod_ff[PROD_W-1:RECIP_SHIFT]};
   assign rem_full = mag_ff - {quot[VALUE_W-4:0], 3'b000} - {quot[VALUE_W-2:0], 1'b0};
   assign mag_in   = value[VALUE_W-1] ? (~value + 32'd1) : value;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff <= mag_in;
         neg_ff <= value[VALUE_W-1];
         cnt_ff <= '0;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(mag_ff) * PROD_W'(RECIP_10);
      end
      if (cmd.dig) begin
         digits_ff[cnt_ff] <= rem_full[DIGIT_W-1:0];
         cnt_ff            <= cnt_ff + 4'd1;
         ptr_ff            <= cnt_ff;
         mag_ff            <= quot;
      end
      if (cmd.step) begin
         ptr_ff <= ptr_ff - 4'd1;
      end
   end

   assign status.negative  = neg_ff;
   assign status.quot_zero = (quot == '0);
   assign status.ptr_zero  = (ptr_ff == '0);

   assign ascii_char = cmd.sel_sign ? CHAR_MINUS
                                    : (CHAR_ZERO + {4'd0, digits_ff[ptr_ff]});
   assign last_char  = !cmd.sel_sign && (ptr_ff == '0);

endmodule

`default_nettype wire

/* rtl/itda_ctrl.sv */
// Controller for the integer-to-decimal-ASCII converter: sequences load,
// digit extraction and character transfers. Uses itda_pkg.
`default_nettype none

module itda_ctrl
   import itda_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIG  = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIG;
         end
         ST_DIG: begin
            cmd.dig = 1'b1;
            if (!status.quot_zero) begin
               state_in = ST_MUL;
            end else if (status.negative) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.ptr_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire
